[rtl/sacl_pkg.sv]
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types, geometry constants and helpers of the set-associative tag
// lookup.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_SETS  = 1024;
    localparam int MAX_WAYS  = 8;
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int SET_W     = $clog2(MAX_SETS);
    localparam int WAY_W     = $clog2(MAX_WAYS);
    localparam int ROW_W     = MAX_WAYS * TAG_W + MAX_WAYS;
    localparam int LFSR_W    = 16;
    localparam int CNT_W     = 32;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0]        WAYS_LOG2_RST = 2'd0;
    localparam logic [3:0]        SET_BITS_RST  = 4'd6;
    localparam logic [3:0]        OFF_BITS_RST  = 4'd4;
    localparam logic [LFSR_W-1:0] SEED_RST      = 16'd1;
    localparam logic [3:0]        SET_BITS_MAX  = 4'(SET_W);

    typedef enum logic [1:0] {
        REG_WAYS_LOG2 = 2'd0,
        REG_SET_BITS  = 2'd1,
        REG_OFF_BITS  = 2'd2,
        REG_LFSR_SEED = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        ways_log2;
        logic [3:0]        set_bits;
        logic [3:0]        offset_bits;
        logic              seed_load;
        logic [LFSR_W-1:0] seed;
    } cfg_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        r = v >> 1;
        if (v[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

endpackage

[rtl/sacl_ram.sv]
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/sacl_regs.sv]
// ----------------------------------------------------------------------------
// sacl_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module sacl_regs
    import sacl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [1:0]        ways_log2_reg;
    logic [3:0]        set_bits_reg;
    logic [3:0]        off_bits_reg;
    logic [LFSR_W-1:0] seed_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_log2_reg <= WAYS_LOG2_RST;
            set_bits_reg  <= SET_BITS_RST;
            off_bits_reg  <= OFF_BITS_RST;
            seed_reg      <= SEED_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_WAYS_LOG2: ways_log2_reg <= pwdata[1:0];
                REG_SET_BITS:  set_bits_reg  <= pwdata[3:0];
                REG_OFF_BITS:  off_bits_reg  <= pwdata[3:0];
                REG_LFSR_SEED: seed_reg      <= pwdata[LFSR_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_WAYS_LOG2: prdata = PDATA_W'(ways_log2_reg);
            REG_SET_BITS:  prdata = PDATA_W'(set_bits_reg);
            REG_OFF_BITS:  prdata = PDATA_W'(off_bits_reg);
            REG_LFSR_SEED: prdata = PDATA_W'(seed_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.ways_log2   = ways_log2_reg;
    assign cfg.set_bits    = set_bits_reg;
    assign cfg.offset_bits = off_bits_reg;
    assign cfg.seed_load   = wr_en && (idx == REG_LFSR_SEED);
    assign cfg.seed        = pwdata[LFSR_W-1:0];

endmodule

[rtl/sacl_lookup.sv]
// ----------------------------------------------------------------------------
// sacl_lookup
// Tag compare across the ways of one set row, lowest-way hit select, and
// victim fill of the row on a miss.
// ----------------------------------------------------------------------------
module sacl_lookup
    import sacl_pkg::*;
(
    input  logic [ROW_W-1:0]  row,
    input  logic [TAG_W-1:0]  tag,
    input  logic [1:0]        ways_log2,
    input  logic [LFSR_W-1:0] lfsr_nx,
    output logic              hit,
    output logic [WAY_W-1:0]  way,
    output logic [ROW_W-1:0]  row_fill
);

    logic [MAX_WAYS-1:0] valid;
    logic [MAX_WAYS-1:0] match;
    logic [WAY_W:0]      ways_n;
    logic [WAY_W-1:0]    way_mask;
    logic [WAY_W-1:0]    hit_way;
    logic [WAY_W-1:0]    victim;

    assign valid    = row[ROW_W-1 -: MAX_WAYS];
    assign ways_n   = (WAY_W+1)'(1) << ways_log2;
    assign way_mask = WAY_W'(ways_n - (WAY_W+1)'(1));
    assign victim   = lfsr_nx[WAY_W-1:0] & way_mask;

    always_comb
    begin
        hit_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            match[w] = valid[w] && (row[w*TAG_W +: TAG_W] == tag)
                       && ((WAY_W+1)'(w) < ways_n);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        row_fill = row;
        row_fill[victim*TAG_W +: TAG_W] = tag;
        row_fill[MAX_WAYS*TAG_W + int'(victim)] = 1'b1;
    end

    assign hit = |match;
    assign way = hit ? hit_way : victim;

endmodule

[rtl/set_assoc_cache_tag_lookup.sv]
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Set-associative tag lookup with LFSR random replacement and saturating
// hit and miss totals.
//
//   channel  dir  handshake          word
//   s_*      in   s_tvalid/s_tready  s_tdata[31:0]  address
//   m_*      out  m_tvalid/m_tready  m_tdata[71:0]  hit, way, hit_count,
//                                                   miss_count
//   apb      in   psel/penable       4 registers at 0x0, 0x4, 0x8, 0xC
//
// Each word first has its set row read from the tag RAM; then the tag is
// compared, and on a miss the row is filled and written back.
// After reset the tag RAM is cleared one row per cycle, all 1024 rows;
// s_tready stays low until then. A held result stalls the compare cycle
// only; the next word is accepted while a result waits on m_*.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup
    import sacl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [ADDR_W-1:0]  s_tdata,   // [31:0] address
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,   // [0] hit, [3:1] way, [35:4] hit_count,
                                          // [67:36] miss_count, [71:68] zero
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } state_t;

    cfg_t              cfg;
    state_t            state_reg;
    state_t            state_next;
    logic [SET_W-1:0]  clr_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_nx;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [WAY_W-1:0]  out_way_reg;

    logic              in_acc;
    logic              done;
    logic [3:0]        sb_eff;
    logic [4:0]        tag_sh;
    logic [SET_W:0]    set_mask;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag_in;

    logic              ram_we;
    logic [SET_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_W-1:0]  ram_rdata;

    logic              lk_hit;
    logic [WAY_W-1:0]  lk_way;
    logic [ROW_W-1:0]  lk_row;

    sacl_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // address split
    assign sb_eff   = (cfg.set_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg.set_bits;
    assign tag_sh   = 5'(cfg.offset_bits) + 5'(sb_eff);
    assign set_mask = ((SET_W+1)'(1) << sb_eff) - (SET_W+1)'(1);
    assign set_idx  = SET_W'(s_tdata >> cfg.offset_bits) & set_mask[SET_W-1:0];
    assign tag_in   = TAG_W'(s_tdata >> tag_sh);

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign done     = (state_reg == ST_LOOK) && (!out_valid_reg || m_tready);
    assign lfsr_nx  = lfsr_step(lfsr_reg);

    sacl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    sacl_lookup u_lookup (
        .row       (ram_rdata),
        .tag       (tag_reg),
        .ways_log2 (cfg.ways_log2),
        .lfsr_nx   (lfsr_nx),
        .hit       (lk_hit),
        .way       (lk_way),
        .row_fill  (lk_row)
    );

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = done && !lk_hit;
            ram_waddr = set_reg;
            ram_wdata = lk_row;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == SET_W'(MAX_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            lfsr_reg      <= SEED_RST;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + SET_W'(1);
            end
            if (cfg.seed_load)
            begin
                lfsr_reg <= cfg.seed;
            end
            else if (done && !lk_hit)
            begin
                lfsr_reg <= lfsr_nx;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
                if (lk_hit)
                begin
                    if (hit_cnt_reg != '1)
                    begin
                        hit_cnt_reg <= hit_cnt_reg + CNT_W'(1);
                    end
                end
                else if (miss_cnt_reg != '1)
                begin
                    miss_cnt_reg <= miss_cnt_reg + CNT_W'(1);
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            set_reg <= set_idx;
            tag_reg <= tag_in;
        end
        if (done)
        begin
            out_hit_reg <= lk_hit;
            out_way_reg <= lk_way;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, miss_cnt_reg, hit_cnt_reg, out_way_reg, out_hit_reg};

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives address words into the set-associative tag lookup under a series of
// cache geometries and replacement seeds, keeps its own copy of the tag
// store, valid bits, replacement generator and totals, and compares every
// hit/way/total word that comes out against that copy in order.
// ----------------------------------------------------------------------------
module testbench;
    import sacl_pkg::*;

    localparam int STORE_N     = MAX_SETS * MAX_WAYS;
    localparam int POOL_N      = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] hit_count;
        logic [WAY_W-1:0] way;
        logic             hit;
    } lookup_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [ADDR_W-1:0]  s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [71:0]        m_tdata;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // cache image kept alongside the block
    logic [TAG_W-1:0]   tag_image [0:STORE_N-1];
    bit                 valid_image [0:STORE_N-1];
    logic [LFSR_W-1:0]  victim_rng;
    logic [CNT_W-1:0]   hits_seen_m;
    logic [CNT_W-1:0]   misses_seen_m;
    logic [1:0]         ways_log2_m   = WAYS_LOG2_RST;
    logic [3:0]         set_bits_m    = SET_BITS_RST;
    logic [3:0]         offset_bits_m = OFF_BITS_RST;

    logic [ADDR_W-1:0]  addr_backlog [$];
    lookup_t            expected_lookups [$];
    logic [ADDR_W-1:0]  recent_addr [0:POOL_N-1];
    int                 pool_fill = 0;
    int                 pool_wr   = 0;

    bit                 calm      = 1'b0;
    bit                 in_taken  = 1'b0;
    int                 hold_seq  = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 cycles    = 0;
    int                 mismatches = 0;
    int                 cfg_errors = 0;
    int                 words_in  = 0;
    int                 words_out = 0;
    int                 hits_out  = 0;
    int                 settings_run = 0;

    set_assoc_cache_tag_lookup uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 clk = ~clk;

    function automatic int live_set_bits();
        return (set_bits_m > SET_W) ? SET_W : int'(set_bits_m);
    endfunction

    function automatic lookup_t cache_lookup(input logic [ADDR_W-1:0] addr);
        lookup_t           r;
        int                sb;
        int                ob;
        int                nways;
        int                base;
        logic [31:0]       set_idx;
        logic [TAG_W-1:0]  tag;
        logic [LFSR_W-1:0] nxt;
        sb = live_set_bits();
        ob = offset_bits_m;
        nways = 1 << ways_log2_m;
        if (nways > MAX_WAYS)
        begin
            nways = MAX_WAYS;
        end
        set_idx = (addr >> ob) & ((32'd1 << sb) - 32'd1);
        tag = addr >> (ob + sb);
        base = set_idx * MAX_WAYS;
        r = '0;
        for (int w = 0; w < nways; w++)
        begin
            if (!r.hit && valid_image[base + w] && tag_image[base + w] == tag)
            begin
                r.hit = 1'b1;
                r.way = WAY_W'(w);
            end
        end
        if (r.hit)
        begin
            if (hits_seen_m != '1)
            begin
                hits_seen_m = hits_seen_m + 1;
            end
        end
        else
        begin
            if (misses_seen_m != '1)
            begin
                misses_seen_m = misses_seen_m + 1;
            end
            nxt = {1'b0, victim_rng[LFSR_W-1:1]};
            if (victim_rng[0])
            begin
                nxt = nxt ^ LFSR_TAPS;
            end
            victim_rng = nxt;
            r.way = WAY_W'(victim_rng & LFSR_W'(nways - 1));
            tag_image[base + r.way] = tag;
            valid_image[base + r.way] = 1'b1;
        end
        r.hit_count = hits_seen_m;
        r.miss_count = misses_seen_m;
        return r;
    endfunction

    // mostly reuse of recent blocks and a few tags per set, so sets fill,
    // hit and evict; the rest is fully random
    function automatic logic [ADDR_W-1:0] pick_address();
        int                r;
        int                sb;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] off_mask;
        sb = live_set_bits();
        off_mask = (32'd1 << offset_bits_m) - 32'd1;
        r = $urandom_range(0, 99);
        if (r >= 15 && r < 65 && pool_fill > 0)
        begin
            return recent_addr[$urandom_range(0, pool_fill - 1)] ^ ($urandom() & off_mask);
        end
        if (r < 15)
        begin
            a = $urandom();
        end
        else
        begin
            a = (32'($urandom_range(0, (1 << ways_log2_m) + 2)) << (offset_bits_m + sb))
                | ((32'($urandom_range(0, 7)) & ((32'd1 << sb) - 32'd1)) << offset_bits_m)
                | ($urandom() & off_mask);
        end
        recent_addr[pool_wr] = a;
        pool_wr = (pool_wr + 1) % POOL_N;
        if (pool_fill < POOL_N)
        begin
            pool_fill = pool_fill + 1;
        end
        return a;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        // read back the register just written
        if (prdata !== val || pready !== 1'b1)
        begin
            cfg_errors = cfg_errors + 1;
            $display("register %0d reads %0h, written %0h", idx, prdata, val);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WAYS_LOG2: ways_log2_m = val[1:0];
            REG_SET_BITS:  set_bits_m = val[3:0];
            REG_OFF_BITS:  offset_bits_m = val[3:0];
            REG_LFSR_SEED: victim_rng = val[LFSR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [1:0] wl, input logic [3:0] sb,
                                input logic [3:0] ob, input logic [LFSR_W-1:0] seed);
        write_reg(REG_WAYS_LOG2, PDATA_W'(wl));
        write_reg(REG_SET_BITS, PDATA_W'(sb));
        write_reg(REG_OFF_BITS, PDATA_W'(ob));
        write_reg(REG_LFSR_SEED, PDATA_W'(seed));
        settings_run = settings_run + 1;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (addr_backlog.size() != 0 || s_tvalid || expected_lookups.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic random_phase(input logic [1:0] wl, input logic [3:0] sb,
                                input logic [3:0] ob, input logic [LFSR_W-1:0] seed,
                                input int n, input bit no_idle, input bit hold);
        set_geometry(wl, sb, ob, seed);
        @(posedge clk);
        calm = no_idle;
        for (int i = 0; i < n; i++)
        begin
            addr_backlog.push_back(pick_address());
        end
        if (hold)
        begin
            hold_seq = hold_seq + 1;
        end
        drain();
    endtask

    // address driver
    always @(negedge clk)
    begin
        if (!s_tvalid || in_taken)
        begin
            if (addr_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 36))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= addr_backlog.pop_front();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result-side backpressure
    always @(negedge clk)
    begin
        m_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 36);
    end

    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor: predict on accepted address, check on accepted result
    always @(posedge clk)
    begin
        lookup_t want;
        lookup_t got;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_lookups.size());
            $display("RESULT: ERROR");
            $finish;
        end
        in_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            expected_lookups.push_back(cache_lookup(s_tdata));
            words_in <= words_in + 1;
        end
        if (m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(lookup_t)-1:0];
            words_out <= words_out + 1;
            if (got.hit)
            begin
                hits_out <= hits_out + 1;
            end
            if (expected_lookups.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                begin
                    $display("unexpected result word %0d: hit %0b way %0d hits %0d misses %0d",
                             words_out, got.hit, got.way, got.hit_count, got.miss_count);
                end
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (got !== want)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                    begin
                        $display({"result word %0d: hit %0b/%0b way %0d/%0d ",
                                  "hits %0d/%0d misses %0d/%0d (exp/got)"},
                                 words_out, want.hit, got.hit, want.way, got.way,
                                 want.hit_count, got.hit_count,
                                 want.miss_count, got.miss_count);
                    end
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < STORE_N; i++)
        begin
            tag_image[i] = '0;
            valid_image[i] = 1'b0;
        end
        victim_rng = SEED_RST;
        hits_seen_m = '0;
        misses_seen_m = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: direct mapped, 64 sets, 16-byte blocks
        addr_backlog = '{32'h0000_0000, 32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF,
                         32'hFFFF_FFF0, 32'h0000_0400, 32'h0000_0000, 32'h0000_03F0,
                         32'h7FFF_FFFF};
        drain();

        // eight ways, set count clamped, no offset, stuck generator
        set_geometry(2'd3, 4'd15, 4'd0, 16'h0000);
        addr_backlog = '{32'h0000_0400, 32'h0000_0800, 32'h0000_0C00, 32'h0000_1000,
                         32'h0000_1400, 32'h0000_1400, 32'h0000_0400, 32'hFFFF_FFFF,
                         32'h0000_0000};
        drain();

        // single set, widest offset; earlier tags stay in place
        set_geometry(2'd3, 4'd0, 4'd15, 16'hFFFF);
        addr_backlog = '{32'h0000_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_0000,
                         32'h0000_7FFF, 32'hFFFF_8000};
        drain();

        random_phase(2'd3, 4'd15, 4'd0, 16'hFFFF, 155, 1'b0, 1'b0);
        random_phase(2'd0, 4'd0, 4'd8, 16'h0001, 155, 1'b0, 1'b0);
        random_phase(2'd1, 4'd10, 4'd15, 16'($urandom_range(1, 65535)), 155, 1'b0, 1'b0);
        random_phase(2'd2, 4'd3, 4'd2, 16'h0000, 155, 1'b0, 1'b0);
        random_phase(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                     155, 1'b1, 1'b0);
        random_phase(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                     155, 1'b0, 1'b1);
        random_phase(2'd3, 4'd4, 4'd4, 16'($urandom_range(1, 65535)), 155, 1'b0, 1'b0);

        repeat (20) @(negedge clk);
        $display("%0d address words in, %0d results out (%0d hits) across %0d geometries",
                 words_in, words_out, hits_out, settings_run);
        $display("covered direct mapped to 8 ways, clamped set counts, zero and full seeds");
        if (mismatches == 0 && cfg_errors == 0 && expected_lookups.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d register errors, %0d results never arrived",
                     mismatches, cfg_errors, expected_lookups.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
